### src/hsps_pkg.sv
// ----------------------------------------------------------------------------
// hsps_pkg
// Shared types, constants and tables for the half-sine pulse stamper.
// ----------------------------------------------------------------------------
package hsps_pkg;

	// Defaults for the top-level parameters
	localparam int DEF_BUFFER_DEPTH    = 512;
	localparam int DEF_MIN_AMPLITUDE   = 1;
	localparam int DEF_AMPLITUDE_COUNT = 255;

	// Position math width: holds any buffer depth up to 4096 and the depth itself
	localparam int POS_W = 13;
	// Point counter width: up to 33 points
	localparam int PT_W  = 6;
	// Sine table index width: 40 entries
	localparam int ROM_W = 6;

	typedef enum logic [1:0] {
		CMD_DRAW  = 2'd0,
		CMD_READ  = 2'd1,
		CMD_WRITE = 2'd2,
		CMD_NOP   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_SCALE = 2'd1,
		ST_BAD_AMP   = 2'd2
	} status_t;

	// Valid scale codes
	localparam logic [7:0] SCALE_W33 = 8'd1;
	localparam logic [7:0] SCALE_W19 = 8'd3;
	localparam logic [7:0] SCALE_W11 = 8'd4;
	localparam logic [7:0] SCALE_W7  = 8'd6;
	localparam logic [7:0] SCALE_W5  = 8'd8;

	// Request payload
	typedef struct packed {
		cmd_t        command;
		logic [7:0]  center_offset;
		logic [7:0]  scale_code;
		logic [7:0]  amplitude;
		logic [8:0]  position;
		logic [7:0]  write_value;
	} hsps_req_t;

	// Result payload
	typedef struct packed {
		logic [7:0]  read_data;
		status_t     status;
	} hsps_res_t;

	// Pulse shape selected by a scale code
	typedef struct packed {
		logic              ok;
		logic [PT_W-1:0]   width;
		logic [PT_W-2:0]   half;
		logic [ROM_W-1:0]  base;
	} shape_t;

	// Controller to datapath
	typedef struct packed {
		logic clear_en;
		logic capture;
		logic start_draw;
		logic step_draw;
		logic write_en;
		logic load_result;
	} hsps_ctl_t;

	// Datapath to controller
	typedef struct packed {
		logic clear_last;
		cmd_t command;
		logic draw_ok;
		logic last_point;
	} hsps_stat_t;

	// Scale code to shape
	function automatic shape_t shape_of(input logic [7:0] code);
		shape_t s;
		s = '{ok: 1'b0, width: '0, half: '0, base: '0};
		case (code)
			SCALE_W33: s = '{ok: 1'b1, width: 6'd33, half: 5'd16, base: 6'd0};
			SCALE_W19: s = '{ok: 1'b1, width: 6'd19, half: 5'd9,  base: 6'd17};
			SCALE_W11: s = '{ok: 1'b1, width: 6'd11, half: 5'd5,  base: 6'd27};
			SCALE_W7:  s = '{ok: 1'b1, width: 6'd7,  half: 5'd3,  base: 6'd33};
			SCALE_W5:  s = '{ok: 1'b1, width: 6'd5,  half: 5'd2,  base: 6'd37};
			default:   s = '{ok: 1'b0, width: '0, half: '0, base: '0};
		endcase
		return s;
	endfunction

	// Half-period sine, 16-bit fraction, per width from its base entry
	function automatic logic [15:0] sine_rom(input logic [ROM_W-1:0] idx);
		logic [15:0] v;
		case (idx)
			// width 33
			6'd0:  v = 16'd0;
			6'd1:  v = 16'd6230;
			6'd2:  v = 16'd12403;
			6'd3:  v = 16'd18464;
			6'd4:  v = 16'd24357;
			6'd5:  v = 16'd30030;
			6'd6:  v = 16'd35431;
			6'd7:  v = 16'd40512;
			6'd8:  v = 16'd45225;
			6'd9:  v = 16'd49529;
			6'd10: v = 16'd53384;
			6'd11: v = 16'd56756;
			6'd12: v = 16'd59614;
			6'd13: v = 16'd61932;
			6'd14: v = 16'd63689;
			6'd15: v = 16'd64869;
			6'd16: v = 16'd65462;
			// width 19
			6'd17: v = 16'd0;
			6'd18: v = 16'd10787;
			6'd19: v = 16'd21280;
			6'd20: v = 16'd31192;
			6'd21: v = 16'd40253;
			6'd22: v = 16'd48216;
			6'd23: v = 16'd54865;
			6'd24: v = 16'd60016;
			6'd25: v = 16'd63531;
			6'd26: v = 16'd65312;
			// width 11
			6'd27: v = 16'd0;
			6'd28: v = 16'd18464;
			6'd29: v = 16'd35431;
			6'd30: v = 16'd49529;
			6'd31: v = 16'd59614;
			6'd32: v = 16'd64869;
			// width 7
			6'd33: v = 16'd0;
			6'd34: v = 16'd28435;
			6'd35: v = 16'd51238;
			6'd36: v = 16'd63893;
			// width 5
			6'd37: v = 16'd0;
			6'd38: v = 16'd38521;
			6'd39: v = 16'd62328;
			default: v = 16'd0;
		endcase
		return v;
	endfunction

endpackage

### src/hsps_ctrl.sv
// ----------------------------------------------------------------------------
// hsps_ctrl
// Sequencer: clearing pass, request decode, point loop and result handoff.
// ----------------------------------------------------------------------------
module hsps_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_ready,
	output logic               res_valid,
	input  logic               res_ready,
	output hsps_pkg::hsps_ctl_t  ctl,
	input  hsps_pkg::hsps_stat_t stat
);
	import hsps_pkg::*;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_DECODE,
		S_DRAW,
		S_DRAIN,
		S_DONE
	} state_t;

	state_t state_q;
	logic   res_valid_q;
	logic   accept;
	logic   go_draw;

	assign cmd_ready = (state_q == S_IDLE);
	assign accept    = cmd_valid && cmd_ready;
	assign go_draw   = (stat.command == CMD_DRAW) && stat.draw_ok;

	// Commands to the datapath
	assign ctl.clear_en    = (state_q == S_CLEAR);
	assign ctl.capture     = accept;
	assign ctl.start_draw  = (state_q == S_DECODE) && go_draw;
	assign ctl.step_draw   = (state_q == S_DRAW);
	assign ctl.write_en    = (state_q == S_DECODE) && (stat.command == CMD_WRITE);
	assign ctl.load_result = (state_q == S_DONE) && (!res_valid_q || res_ready);

	assign res_valid = res_valid_q;

	// State and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			res_valid_q <= 1'b0;
		end else begin
			if (ctl.load_result) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					if (stat.clear_last) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (accept) state_q <= S_DECODE;
				end
				S_DECODE: begin
					state_q <= go_draw ? S_DRAW : S_DONE;
				end
				S_DRAW: begin
					if (stat.last_point) state_q <= S_DRAIN;
				end
				S_DRAIN: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (ctl.load_result) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

### src/hsps_dp.sv
// ----------------------------------------------------------------------------
// hsps_dp
// Pulse buffer memory, point address and sine scaling pipeline, result register.
// ----------------------------------------------------------------------------
module hsps_dp #(
	parameter int BUFFER_DEPTH    = hsps_pkg::DEF_BUFFER_DEPTH,
	parameter int MIN_AMPLITUDE   = hsps_pkg::DEF_MIN_AMPLITUDE,
	parameter int AMPLITUDE_COUNT = hsps_pkg::DEF_AMPLITUDE_COUNT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  hsps_pkg::hsps_ctl_t  ctl,
	output hsps_pkg::hsps_stat_t stat,
	input  hsps_pkg::hsps_req_t  cmd,
	output hsps_pkg::hsps_res_t  res
);
	import hsps_pkg::*;

	localparam int AW = $clog2(BUFFER_DEPTH);

	// Buffer and registered read
	logic [7:0]       mem_q [BUFFER_DEPTH];
	logic [7:0]       rd_data_q;
	logic [AW-1:0]    rd_addr;

	// Request and result
	hsps_req_t        req_q;
	hsps_res_t        res_q;

	// Control counters
	logic [AW-1:0]    clr_q;
	logic [PT_W-1:0]  pt_q;

	// Point pipeline
	logic             v_s1;
	logic [AW-1:0]    addr_s1;
	logic [15:0]      sine_s1;
	logic             wr_s2;
	logic [AW-1:0]    addr_s2;
	logic [7:0]       val_s2;

	shape_t           shape;
	logic [9:0]       amp_x;
	logic             amp_ok;
	logic [POS_W-1:0] req_pos;
	logic             req_pos_ok;
	logic [POS_W-1:0] pt_sum;
	logic [POS_W-1:0] pt_pos;
	logic             pt_ok;
	logic [PT_W-2:0]  pt_k;
	logic [ROM_W-1:0] rom_idx;
	logic [23:0]      prod;
	status_t          draw_status;

	// Request decode
	assign shape      = shape_of(req_q.scale_code);
	assign amp_x      = 10'(req_q.amplitude);
	assign amp_ok     = (amp_x >= 10'(MIN_AMPLITUDE)) &&
	                    (amp_x <  10'(MIN_AMPLITUDE + AMPLITUDE_COUNT));
	assign req_pos    = POS_W'(req_q.position);
	assign req_pos_ok = req_pos < POS_W'(BUFFER_DEPTH);

	always_comb begin
		if (!shape.ok) begin
			draw_status = ST_BAD_SCALE;
		end else if (!amp_ok) begin
			draw_status = ST_BAD_AMP;
		end else begin
			draw_status = ST_OK;
		end
	end

	assign stat.clear_last = (clr_q == AW'(BUFFER_DEPTH - 1));
	assign stat.command    = req_q.command;
	assign stat.draw_ok    = shape.ok && amp_ok;
	assign stat.last_point = (pt_q == shape.width - PT_W'(1));

	// Point position; points left of entry zero or past the end are dropped
	assign pt_sum = POS_W'(req_q.center_offset) + POS_W'(pt_q);
	assign pt_pos = pt_sum - POS_W'(shape.half);
	assign pt_ok  = (pt_sum >= POS_W'(shape.half)) && (pt_pos < POS_W'(BUFFER_DEPTH));

	// Mirror index into the half-period table
	assign pt_k    = (pt_q <= PT_W'(shape.half)) ? pt_q[PT_W-2:0]
	                                             : (PT_W-1)'(shape.width - pt_q);
	assign rom_idx = shape.base + ROM_W'(pt_k);

	assign rd_addr = ctl.step_draw ? pt_pos[AW-1:0] : req_pos[AW-1:0];

	// Amplitude times sine, integer part
	assign prod = 24'(req_q.amplitude) * 24'(sine_s1);

	// Request capture
	always_ff @(posedge clk) begin
		if (ctl.capture) req_q <= cmd;
	end

	// Counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			pt_q  <= '0;
			v_s1  <= 1'b0;
			wr_s2 <= 1'b0;
		end else begin
			if (ctl.clear_en) clr_q <= clr_q + AW'(1);
			if (ctl.start_draw) begin
				pt_q <= '0;
			end else if (ctl.step_draw) begin
				pt_q <= pt_q + PT_W'(1);
			end
			v_s1  <= ctl.step_draw && pt_ok;
			wr_s2 <= v_s1 && (rd_data_q == 8'd0);
		end
	end

	// Pipeline payload
	always_ff @(posedge clk) begin
		addr_s1 <= pt_pos[AW-1:0];
		sine_s1 <= sine_rom(rom_idx);
		addr_s2 <= addr_s1;
		val_s2  <= prod[23:16];
	end

	// Buffer: one write port, one registered read port
	always_ff @(posedge clk) begin
		rd_data_q <= mem_q[rd_addr];
		if (ctl.clear_en) begin
			mem_q[clr_q] <= 8'd0;
		end else if (ctl.write_en && req_pos_ok) begin
			mem_q[req_pos[AW-1:0]] <= req_q.write_value;
		end else if (wr_s2) begin
			mem_q[addr_s2] <= val_s2;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (ctl.load_result) begin
			res_q.read_data <= ((req_q.command == CMD_READ) && req_pos_ok) ? rd_data_q : 8'd0;
			res_q.status    <= (req_q.command == CMD_DRAW) ? draw_status : ST_OK;
		end
	end

	assign res = res_q;

endmodule

### src/half_sine_pulse_stamper_core.sv
// ----------------------------------------------------------------------------
// half_sine_pulse_stamper_core
// Byte waveform buffer with draw (half-sine pulse), read and write requests.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-------------------------
//   request  | cmd_valid, cmd_ready | cmd  (hsps_req_t)
//   result   | res_valid, res_ready | res  (hsps_res_t)
//
// A draw steps through W points (W = 33, 19, 11, 7 or 5), one point per cycle
// through the buffer's single read and write port, then through the scale and
// write stages before its result. Other requests skip the point loop.
// After reset a clearing pass zeroes one entry per cycle over all BUFFER_DEPTH
// entries and holds off requests. A finished result waits in an output register
// while the next request is taken; that result then waits for the register.
// ----------------------------------------------------------------------------
module half_sine_pulse_stamper_core #(
	parameter int BUFFER_DEPTH    = hsps_pkg::DEF_BUFFER_DEPTH,
	parameter int MIN_AMPLITUDE   = hsps_pkg::DEF_MIN_AMPLITUDE,
	parameter int AMPLITUDE_COUNT = hsps_pkg::DEF_AMPLITUDE_COUNT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_ready,
	input  hsps_pkg::hsps_req_t cmd,
	output logic                res_valid,
	input  logic                res_ready,
	output hsps_pkg::hsps_res_t res
);
	import hsps_pkg::*;

	hsps_ctl_t  ctl;
	hsps_stat_t stat;

	hsps_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.ctl       (ctl),
		.stat      (stat)
	);

	hsps_dp #(
		.BUFFER_DEPTH    (BUFFER_DEPTH),
		.MIN_AMPLITUDE   (MIN_AMPLITUDE),
		.AMPLITUDE_COUNT (AMPLITUDE_COUNT)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.stat   (stat),
		.cmd    (cmd),
		.res    (res)
	);

	// Buffer write sources and request capture never overlap
	a_excl_cmds: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ctl.clear_en, ctl.capture, ctl.step_draw, ctl.write_en}))
		else $error("overlapping datapath commands");

	// Busy right after a request is taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && cmd_ready) |=> !cmd_ready)
		else $error("request taken while busy");

	// A draw start is followed by the point loop
	a_draw_starts: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.start_draw |=> ctl.step_draw)
		else $error("draw started without point loop");

	// The point loop ends on its last point
	a_draw_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.step_draw && stat.last_point) |=> !ctl.step_draw)
		else $error("point loop ran past last point");

endmodule
